### hdl/ole_pkg.sv
package ole_pkg;

	localparam logic [2:0] CMD_ADD_FRONT = 3'd0;
	localparam logic [2:0] CMD_ADD_REAR  = 3'd1;
	localparam logic [2:0] CMD_INSERT_AT = 3'd2;
	localparam logic [2:0] CMD_DEL_FRONT = 3'd3;
	localparam logic [2:0] CMD_DEL_REAR  = 3'd4;
	localparam logic [2:0] CMD_DEL_AT    = 3'd5;
	localparam logic [2:0] CMD_SEARCH    = 3'd6;

	localparam logic [1:0] STAT_OK     = 2'd0;
	localparam logic [1:0] STAT_EMPTY  = 2'd1;
	localparam logic [1:0] STAT_BADPOS = 2'd2;
	localparam logic [1:0] STAT_FULL   = 2'd3;

	localparam logic [6:0] FOUND_NONE = 7'h7F;

	typedef enum logic [1:0] {
		OP_NONE,
		OP_INSERT,
		OP_REMOVE,
		OP_SEARCH
	} op_t;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_EXEC,
		ST_SCAN,
		ST_DONE
	} state_t;

	typedef struct packed {
		logic insert;
		logic remove;
		logic search;
	} cell_ctrl_t;

endpackage

### hdl/ole_cell.sv
module ole_cell
	import ole_pkg::*;
#(
	parameter int VALUE_WIDTH = 32,
	parameter int IDX_W       = 6,
	parameter int CNT_W       = 7,
	parameter int INDEX       = 0
) (
	input  logic                   clk,
	input  cell_ctrl_t             ctrl,
	input  logic [IDX_W-1:0]       at,
	input  logic [CNT_W-1:0]       count,
	input  logic [VALUE_WIDTH-1:0] key,
	input  logic [VALUE_WIDTH-1:0] left_value,
	input  logic [VALUE_WIDTH-1:0] right_value,
	output logic [VALUE_WIDTH-1:0] value,
	input  logic                   hit_in,
	input  logic [IDX_W-1:0]       idx_in,
	input  logic [VALUE_WIDTH-1:0] data_in,
	output logic                   hit_out,
	output logic [IDX_W-1:0]       idx_out,
	output logic [VALUE_WIDTH-1:0] data_out
);

	localparam logic [IDX_W-1:0] MY_IDX = IDX_W'(INDEX);
	localparam logic [CNT_W-1:0] MY_CNT = CNT_W'(INDEX);

	logic [VALUE_WIDTH-1:0] entry_q;
	logic                   hit_q;
	logic [IDX_W-1:0]       idx_q;
	logic [VALUE_WIDTH-1:0] data_q;
	logic                   sel;

	assign sel = ctrl.search ? ((MY_CNT < count) && (entry_q == key)) : (MY_IDX == at);

	always_ff @(posedge clk) begin
		if (ctrl.insert && MY_IDX == at) begin
			entry_q <= key;
		end else if (ctrl.insert && MY_IDX > at) begin
			entry_q <= left_value;
		end else if (ctrl.remove && MY_IDX >= at) begin
			entry_q <= right_value;
		end
	end

	// first hit from the front travels down the row unchanged
	always_ff @(posedge clk) begin
		if (hit_in) begin
			hit_q  <= 1'b1;
			idx_q  <= idx_in;
			data_q <= data_in;
		end else begin
			hit_q  <= sel;
			idx_q  <= MY_IDX;
			data_q <= entry_q;
		end
	end

	assign value    = entry_q;
	assign hit_out  = hit_q;
	assign idx_out  = idx_q;
	assign data_out = data_q;

endmodule

### hdl/ordered_list_engine.sv
// channel | signals                                   | direction
// in      | in_valid, in_ready, cmd, position, value  | beat into the list
// out     | out_valid, out_ready, status, removed_value,| beat of one result
//         | found_index, list_length, is_empty        |
// Adds, inserts, failed deletes and unknown commands: result loaded from EXEC once the output is free.
// Successful deletes and all searches: a hit ripples through the cell row, one cell per cycle,
// in SCAN; the result is formed in DONE and loaded once the output register is free.
// in_ready returns the cycle after a result is loaded; a new beat is accepted while a result
// waits in the output register, and its own result is held until that one is taken.
// arst_n clears the length, the control state and the output valid; entries stay.
module ordered_list_engine
	import ole_pkg::*;
#(
	parameter int DEPTH       = 64,
	parameter int VALUE_WIDTH = 32
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               in_valid,
	output logic               in_ready,
	input  logic [2:0]         cmd,
	input  logic signed [7:0]  position,
	input  logic signed [31:0] value,
	output logic               out_valid,
	input  logic               out_ready,
	output logic [1:0]         status,
	output logic signed [31:0] removed_value,
	output logic signed [6:0]  found_index,
	output logic [6:0]         list_length,
	output logic               is_empty
);

	localparam int IDX_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CNT_W = $clog2(DEPTH + 1);
	localparam int CW    = (CNT_W > 8) ? CNT_W : 8;
	localparam logic [CNT_W-1:0] FULL_CNT  = CNT_W'(DEPTH);
	localparam logic [IDX_W-1:0] LAST_SCAN = IDX_W'(DEPTH - 1);

	state_t                 state_q, state_d;
	op_t                    op_q, dec_op;
	logic [1:0]             stat_q, dec_stat;
	logic [IDX_W-1:0]       at_q, dec_at;
	logic [VALUE_WIDTH-1:0] key_q, in_val;
	logic [CNT_W-1:0]       count_q, count_d;
	logic [IDX_W-1:0]       scan_q;
	logic                   out_valid_q;
	logic [1:0]             status_q, res_status;
	logic [31:0]            removed_q, res_removed;
	logic [6:0]             found_q, res_found;
	logic [6:0]             length_q;
	logic                   empty_q;
	logic                   out_free, load_out, accept;
	cell_ctrl_t             ctrl;
	logic                   pos_neg;
	logic [CW-1:0]          posx, cntx;
	logic [VALUE_WIDTH+31:0] in_ext;
	logic [VALUE_WIDTH+31:0] rm_ext;

	logic [VALUE_WIDTH-1:0] entry_w [DEPTH];
	logic                   hit_w   [DEPTH+1];
	logic [IDX_W-1:0]       idx_w   [DEPTH+1];
	logic [VALUE_WIDTH-1:0] data_w  [DEPTH+1];

	assign in_ext  = {{VALUE_WIDTH{1'b0}}, value};
	assign in_val  = in_ext[VALUE_WIDTH-1:0];
	assign pos_neg = position[7];
	assign posx    = CW'(position[6:0]);
	assign cntx    = CW'(count_q);
	assign accept  = in_valid && in_ready;
	assign out_free = !out_valid_q || out_ready;

	always_comb begin
		dec_op   = OP_NONE;
		dec_stat = STAT_BADPOS;
		dec_at   = '0;
		unique case (cmd)
			CMD_ADD_FRONT, CMD_ADD_REAR, CMD_INSERT_AT: begin
				if (cmd == CMD_INSERT_AT && (pos_neg || posx > cntx)) begin
					dec_stat = STAT_BADPOS;
				end else if (count_q == FULL_CNT) begin
					dec_stat = STAT_FULL;
				end else begin
					dec_op   = OP_INSERT;
					dec_stat = STAT_OK;
					if (cmd == CMD_ADD_REAR) begin
						dec_at = count_q[IDX_W-1:0];
					end else if (cmd == CMD_INSERT_AT) begin
						dec_at = posx[IDX_W-1:0];
					end
				end
			end
			CMD_DEL_FRONT, CMD_DEL_REAR, CMD_DEL_AT: begin
				if (count_q == '0) begin
					dec_stat = STAT_EMPTY;
				end else if (cmd == CMD_DEL_AT && (pos_neg || posx >= cntx)) begin
					dec_stat = STAT_BADPOS;
				end else begin
					dec_op   = OP_REMOVE;
					dec_stat = STAT_OK;
					if (cmd == CMD_DEL_REAR) begin
						dec_at = IDX_W'(count_q - CNT_W'(1));
					end else if (cmd == CMD_DEL_AT) begin
						dec_at = posx[IDX_W-1:0];
					end
				end
			end
			CMD_SEARCH: begin
				dec_op = OP_SEARCH;
			end
			default: begin
				dec_op = OP_NONE;
			end
		endcase
	end

	assign rm_ext = {32'b0, data_w[DEPTH]};

	always_comb begin
		state_d     = state_q;
		in_ready    = 1'b0;
		load_out    = 1'b0;
		ctrl        = '0;
		ctrl.search = (op_q == OP_SEARCH);
		count_d     = count_q;
		res_status  = stat_q;
		res_removed = '0;
		res_found   = FOUND_NONE;
		unique case (state_q)
			ST_IDLE: begin
				in_ready = 1'b1;
				if (in_valid) begin
					state_d = ST_EXEC;
				end
			end
			ST_EXEC: begin
				if (op_q == OP_SEARCH || op_q == OP_REMOVE) begin
					state_d = ST_SCAN;
				end else if (out_free) begin
					load_out    = 1'b1;
					ctrl.insert = (op_q == OP_INSERT);
					if (op_q == OP_INSERT) begin
						count_d = count_q + CNT_W'(1);
					end
					state_d = ST_IDLE;
				end
			end
			ST_SCAN: begin
				if (scan_q == LAST_SCAN) begin
					state_d = ST_DONE;
				end
			end
			ST_DONE: begin
				if (op_q == OP_REMOVE) begin
					res_status  = STAT_OK;
					res_removed = rm_ext[31:0];
				end else if (hit_w[DEPTH]) begin
					res_status = STAT_OK;
					res_found  = 7'(idx_w[DEPTH]);
				end else begin
					res_status = STAT_BADPOS;
				end
				if (out_free) begin
					load_out    = 1'b1;
					ctrl.remove = (op_q == OP_REMOVE);
					if (op_q == OP_REMOVE) begin
						count_d = count_q - CNT_W'(1);
					end
					state_d = ST_IDLE;
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			count_q     <= '0;
			scan_q      <= '0;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			count_q <= count_d;
			scan_q  <= (state_q == ST_SCAN) ? scan_q + IDX_W'(1) : '0;
			if (load_out) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			op_q   <= dec_op;
			stat_q <= dec_stat;
			at_q   <= dec_at;
			key_q  <= in_val;
		end
		if (load_out) begin
			status_q  <= res_status;
			removed_q <= res_removed;
			found_q   <= res_found;
			length_q  <= 7'(count_d);
			empty_q   <= (count_d == '0);
		end
	end

	assign hit_w[0]  = 1'b0;
	assign idx_w[0]  = '0;
	assign data_w[0] = '0;

	for (genvar i = 0; i < DEPTH; i++) begin : g_cell
		logic [VALUE_WIDTH-1:0] left_v, right_v;
		if (i == 0) begin : g_first
			assign left_v = '0;
		end else begin : g_mid
			assign left_v = entry_w[i-1];
		end
		if (i == DEPTH - 1) begin : g_last
			assign right_v = '0;
		end else begin : g_inner
			assign right_v = entry_w[i+1];
		end
		ole_cell #(
			.VALUE_WIDTH(VALUE_WIDTH),
			.IDX_W      (IDX_W),
			.CNT_W      (CNT_W),
			.INDEX      (i)
		) u_cell (
			.clk        (clk),
			.ctrl       (ctrl),
			.at         (at_q),
			.count      (count_q),
			.key        (key_q),
			.left_value (left_v),
			.right_value(right_v),
			.value      (entry_w[i]),
			.hit_in     (hit_w[i]),
			.idx_in     (idx_w[i]),
			.data_in    (data_w[i]),
			.hit_out    (hit_w[i+1]),
			.idx_out    (idx_w[i+1]),
			.data_out   (data_w[i+1])
		);
	end

	assign out_valid     = out_valid_q;
	assign status        = status_q;
	assign removed_value = removed_q;
	assign found_index   = found_q;
	assign list_length   = length_q;
	assign is_empty      = empty_q;

	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= FULL_CNT)
		else $error("list length beyond depth");

	a_remove_hit: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_DONE && op_q == OP_REMOVE) |-> hit_w[DEPTH])
		else $error("delete target not seen at end of cell row");

	a_insert_grows: assert property (@(posedge clk) disable iff (!arst_n)
		ctrl.insert |=> count_q == $past(count_q) + CNT_W'(1))
		else $error("insert did not grow the list");

	a_no_commit_busy: assert property (@(posedge clk) disable iff (!arst_n)
		load_out |-> (out_free && (state_q == ST_EXEC || state_q == ST_DONE)))
		else $error("result loaded while output held or outside commit state");

endmodule

### dv/ole_tb_pkg.sv
`timescale 1ns / 100ps

package ole_tb_pkg;
	import ole_pkg::*;

	localparam int         LIST_DEPTH  = 64;
	localparam logic [2:0] CMD_UNKNOWN = 3'd7;

	typedef struct packed {
		logic [1:0]  status;
		logic [31:0] removed_value;
		logic [6:0]  found_index;
		logic [6:0]  list_length;
		logic        is_empty;
	} list_result_t;

	class list_tracker;
		logic [31:0]  shadow_entries [LIST_DEPTH];
		int           shadow_count;
		list_result_t pending_results [$];
		int unsigned  errors;
		int unsigned  n_checked;
		int unsigned  n_full_rejects;
		int unsigned  n_empty_deletes;
		int unsigned  n_search_hits;
		int unsigned  n_bad_outcomes;
		int unsigned  n_reached_full;

		function new();
			shadow_count = 0;
			errors = 0;
			n_checked = 0;
			n_full_rejects = 0;
			n_empty_deletes = 0;
			n_search_hits = 0;
			n_bad_outcomes = 0;
			n_reached_full = 0;
		endfunction

		function int length();
			return shadow_count;
		endfunction

		function logic [31:0] entry(int idx);
			return shadow_entries[idx];
		endfunction

		function int pending();
			return pending_results.size();
		endfunction

		// predict one command and advance the shadow list
		function void note_command(logic [2:0] op, logic signed [7:0] pos_in,
			logic [31:0] val);
			list_result_t r;
			int pos;
			int at;
			r.status = STAT_OK;
			r.removed_value = '0;
			r.found_index = FOUND_NONE;
			pos = int'(pos_in);
			case (op)
				CMD_ADD_FRONT, CMD_ADD_REAR, CMD_INSERT_AT: begin
					if (op == CMD_ADD_FRONT)
						at = 0;
					else if (op == CMD_ADD_REAR)
						at = shadow_count;
					else
						at = pos;
					if (op == CMD_INSERT_AT && (pos < 0 || pos > shadow_count))
						r.status = STAT_BADPOS;
					else if (shadow_count >= LIST_DEPTH)
						r.status = STAT_FULL;
					else begin
						for (int i = shadow_count; i > at; i--)
							shadow_entries[i] = shadow_entries[i-1];
						shadow_entries[at] = val;
						shadow_count++;
						if (shadow_count == LIST_DEPTH)
							n_reached_full++;
					end
				end
				CMD_DEL_FRONT, CMD_DEL_REAR, CMD_DEL_AT: begin
					if (op == CMD_DEL_FRONT)
						at = 0;
					else if (op == CMD_DEL_REAR)
						at = shadow_count - 1;
					else
						at = pos;
					if (shadow_count == 0)
						r.status = STAT_EMPTY;
					else if (op == CMD_DEL_AT && (pos < 0 || pos >= shadow_count))
						r.status = STAT_BADPOS;
					else begin
						r.removed_value = shadow_entries[at];
						for (int i = at; i < shadow_count - 1; i++)
							shadow_entries[i] = shadow_entries[i+1];
						shadow_count--;
					end
				end
				CMD_SEARCH: begin
					r.status = STAT_BADPOS;
					for (int i = 0; i < shadow_count; i++) begin
						if (r.status != STAT_OK && shadow_entries[i] == val) begin
							r.status = STAT_OK;
							r.found_index = 7'(i);
						end
					end
					if (r.status == STAT_OK)
						n_search_hits++;
				end
				default: r.status = STAT_BADPOS;
			endcase
			r.list_length = 7'(shadow_count);
			r.is_empty = shadow_count == 0;
			if (r.status == STAT_FULL)
				n_full_rejects++;
			if (r.status == STAT_EMPTY)
				n_empty_deletes++;
			if (r.status == STAT_BADPOS)
				n_bad_outcomes++;
			pending_results.push_back(r);
		endfunction

		function void check_result(list_result_t got);
			list_result_t want;
			if (pending_results.size() == 0) begin
				$error("result beat with nothing expected");
				errors++;
				return;
			end
			want = pending_results.pop_front();
			n_checked++;
			if (got.status !== want.status) begin
				$error("status: expected %0d, got %0d", want.status, got.status);
				errors++;
			end
			if (got.removed_value !== want.removed_value) begin
				$error("removed_value: expected %0d, got %0d",
					$signed(want.removed_value), $signed(got.removed_value));
				errors++;
			end
			if (got.found_index !== want.found_index) begin
				$error("found_index: expected %0d, got %0d",
					$signed(want.found_index), $signed(got.found_index));
				errors++;
			end
			if (got.list_length !== want.list_length) begin
				$error("list_length: expected %0d, got %0d",
					want.list_length, got.list_length);
				errors++;
			end
			if (got.is_empty !== want.is_empty) begin
				$error("is_empty: expected %0d, got %0d", want.is_empty, got.is_empty);
				errors++;
			end
		endfunction
	endclass

endpackage

### dv/testbench.sv
`timescale 1ns / 100ps

module testbench;
	import ole_pkg::*;
	import ole_tb_pkg::*;

	localparam int N_RANDOM   = 1128;
	localparam int QUIET_TAIL = 150;

	logic               clk;
	logic               arst_n = 1'b0;
	logic               in_valid = 1'b0;
	logic               in_ready;
	logic [2:0]         cmd = CMD_ADD_FRONT;
	logic signed [7:0]  position = '0;
	logic signed [31:0] value = '0;
	logic               out_valid;
	logic               out_ready;
	logic [1:0]         status;
	logic signed [31:0] removed_value;
	logic signed [6:0]  found_index;
	logic [6:0]         list_length;
	logic               is_empty;

	bit quiet = 1'b0;
	bit filling = 1'b1;
	bit send_idle = 1'b1;

	list_tracker tracker = new();

	ordered_list_engine dut (
		.clk           (clk),
		.arst_n        (arst_n),
		.in_valid      (in_valid),
		.in_ready      (in_ready),
		.cmd           (cmd),
		.position      (position),
		.value         (value),
		.out_valid     (out_valid),
		.out_ready     (out_ready),
		.status        (status),
		.removed_value (removed_value),
		.found_index   (found_index),
		.list_length   (list_length),
		.is_empty      (is_empty)
	);

	always begin
		clk = 1'b0;
		#5;
		clk = 1'b1;
		#5;
	end

	always @(posedge clk) begin
		if (arst_n) begin
			if (out_valid && out_ready)
				tracker.check_result({status, removed_value, found_index,
					list_length, is_empty});
			if (in_valid && in_ready)
				tracker.note_command(cmd, position, value);
		end
	end

	// called at a falling edge, returns at the falling edge after the beat
	task automatic send_beat(input logic [2:0] c, input logic signed [7:0] p,
		input logic signed [31:0] v);
		in_valid = 1'b1;
		cmd = c;
		position = p;
		value = v;
		do
			@(posedge clk);
		while (!in_ready);
		@(negedge clk);
	endtask

	function automatic logic [31:0] pick_value();
		int r;
		r = $urandom_range(0, 9);
		if (r < 4)
			return 32'($urandom_range(0, 15));
		if (r == 4) begin
			case ($urandom_range(0, 3))
				0: return 32'h8000_0000;
				1: return 32'h7FFF_FFFF;
				2: return 32'hFFFF_FFFF;
				default: return 32'h0;
			endcase
		end
		return $urandom;
	endfunction

	function automatic logic signed [7:0] pick_position(int len);
		int r;
		r = $urandom_range(0, 9);
		if (r < 5)
			return 8'($urandom_range(0, len));
		if (r < 7) begin
			case ($urandom_range(0, 2))
				0: return -8'sd1;
				1: return 8'(len);
				default: return 8'(len + 1);
			endcase
		end
		return 8'($urandom);
	endfunction

	initial begin
		out_ready = 1'b0;
		@(posedge arst_n);
		@(negedge clk);
		forever begin
			if (quiet || $urandom_range(0, 15) == 0) begin
				out_ready = 1'b1;
				repeat ($urandom_range(100, 300)) @(negedge clk);
			end else if ($urandom_range(0, 3) != 0) begin
				out_ready = 1'b1;
				repeat ($urandom_range(1, 30)) @(negedge clk);
			end else begin
				out_ready = 1'b0;
				repeat ($urandom_range(1, 19)) @(negedge clk);
			end
		end
	end

	initial begin
		logic [2:0]         c;
		logic signed [7:0]  p;
		logic signed [31:0] v;
		int                 len;
		int                 r;
		int                 add_share;
		int                 del_share;

		repeat (3) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;
		@(negedge clk);

		// empty list corners
		send_beat(CMD_DEL_FRONT, 8'sd0, 32'h0);
		send_beat(CMD_DEL_REAR, 8'sd0, 32'h0);
		send_beat(CMD_DEL_AT, -8'sd128, 32'h0);
		send_beat(CMD_SEARCH, 8'sd0, 32'h0);
		send_beat(CMD_INSERT_AT, 8'sd1, 32'h1234_5678);
		send_beat(CMD_INSERT_AT, -8'sd1, 32'h1234_5678);
		// build a short list, then search it, send an unknown command and delete from it
		send_beat(CMD_INSERT_AT, 8'sd0, 32'h7FFF_FFFF);
		send_beat(CMD_ADD_FRONT, 8'sd0, 32'h8000_0000);
		send_beat(CMD_ADD_REAR, 8'sd0, 32'h0);
		send_beat(CMD_ADD_REAR, 8'sd0, 32'hFFFF_FFFF);
		send_beat(CMD_INSERT_AT, 8'sd4, 32'h5555_5555);
		send_beat(CMD_INSERT_AT, 8'sd127, 32'hAAAA_AAAA);
		send_beat(CMD_INSERT_AT, -8'sd128, 32'hAAAA_AAAA);
		send_beat(CMD_SEARCH, 8'sd0, 32'hFFFF_FFFF);
		send_beat(CMD_SEARCH, -8'sd1, 32'hAAAA_AAAA);
		send_beat(CMD_UNKNOWN, 8'sd3, 32'h0);
		send_beat(CMD_DEL_AT, 8'sd5, 32'h0);
		send_beat(CMD_DEL_AT, -8'sd1, 32'h0);
		send_beat(CMD_DEL_AT, 8'sd2, 32'h0);
		send_beat(CMD_DEL_FRONT, 8'sd0, 32'h0);
		send_beat(CMD_DEL_REAR, 8'sd0, 32'h0);
		send_beat(CMD_DEL_AT, 8'sd0, 32'h0);

		for (int n = 0; n < N_RANDOM; n++) begin
			if (n % 64 == 0)
				send_idle = $urandom_range(0, 9) < 7;
			quiet = n >= N_RANDOM - QUIET_TAIL;
			if (!quiet && send_idle && $urandom_range(0, 3) == 0) begin
				in_valid = 1'b0;
				repeat ($urandom_range(1, 19)) @(negedge clk);
			end

			// alternate between filling toward full and draining toward empty
			len = tracker.length();
			if (len == LIST_DEPTH && $urandom_range(0, 3) == 0)
				filling = 1'b0;
			else if (len == 0 && $urandom_range(0, 3) == 0)
				filling = 1'b1;
			else if ($urandom_range(0, 149) == 0)
				filling = !filling;

			add_share = filling ? 60 : 15;
			del_share = filling ? 15 : 60;
			r = $urandom_range(0, 99);
			if (r < add_share) begin
				case ($urandom_range(0, 2))
					0: c = CMD_ADD_FRONT;
					1: c = CMD_ADD_REAR;
					default: c = CMD_INSERT_AT;
				endcase
			end else if (r < add_share + del_share) begin
				case ($urandom_range(0, 2))
					0: c = CMD_DEL_FRONT;
					1: c = CMD_DEL_REAR;
					default: c = CMD_DEL_AT;
				endcase
			end else if (r < 97)
				c = CMD_SEARCH;
			else
				c = CMD_UNKNOWN;

			if (c == CMD_SEARCH && len > 0 && $urandom_range(0, 9) < 6)
				v = tracker.entry($urandom_range(0, len - 1));
			else
				v = pick_value();
			p = pick_position(len);
			send_beat(c, p, v);
		end
		in_valid = 1'b0;

		while (tracker.pending() != 0)
			@(posedge clk);
		repeat (LIST_DEPTH + 8) @(posedge clk);

		$display("%0d results checked; %0d search hits, %0d bad-position or miss results",
			tracker.n_checked, tracker.n_search_hits, tracker.n_bad_outcomes);
		$display("list filled to capacity %0d times, %0d full rejects, %0d empty deletes",
			tracker.n_reached_full, tracker.n_full_rejects, tracker.n_empty_deletes);
		if (tracker.errors == 0)
			$display("Testbench completed without errors");
		else
			$display("Testbench completed WITH ERRORS");
		$finish;
	end

	initial begin
		#10_000_000;
		$display("timeout with %0d results outstanding", tracker.pending());
		$display("Testbench completed WITH ERRORS");
		$finish;
	end

endmodule
